// ===== hw/rtl/anp_pkg.sv =====
// Shared types and constants of the ASCII number token parser.
package anp_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR  = 2'd2;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_X     = 8'h78;

    // Reset values of the configuration registers.
    localparam logic [7:0] SEPARATOR_RESET  = 8'd32;
    localparam logic [7:0] TERMINATOR_RESET = 8'd13;

    // Decimal limits.
    localparam logic [19:0] LIMIT_SIGNED_POS = 20'd32767;
    localparam logic [19:0] LIMIT_SIGNED_NEG = 20'd32768;
    localparam logic [19:0] LIMIT_UNSIGNED   = 20'd65535;

    localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;

    typedef struct packed {
        logic       signed_mode;
        logic [7:0] separator_char;
        logic [7:0] terminator_char;
    } cfg_t;

    typedef struct packed {
        logic [15:0] accum;
        logic        is_negative;
        logic        is_hex;
        logic        at_start;
        logic        failed;
        logic [2:0]  hex_digit_count;
        logic        x_pending;
    } tok_state_t;

    localparam tok_state_t TOK_CLEAR = '{
        accum:           16'd0,
        is_negative:     1'b0,
        is_hex:          1'b0,
        at_start:        1'b1,
        failed:          1'b0,
        hex_digit_count: 3'd0,
        x_pending:       1'b0
    };

    typedef struct packed {
        logic        emit;
        logic [15:0] value_out;
        logic        ok;
    } tok_result_t;

endpackage

// ===== hw/rtl/ascii_number_token_parser.sv =====
// Top level of the ASCII number token parser: input register, token state, result register.
//
//  Channel   Direction  Ports                          Moves
//  s_        in         s_valid s_ready s_char_in      one character per transfer
//  m_        out        m_valid m_ready m_value_out    one parsed token per transfer
//                       m_ok
//  cfg_      in         cfg_wr_en cfg_index cfg_wdata  register write, no handshake
//
//  A character is taken every cycle as long as the result side keeps up; a
//  result is loaded into the result register from the input register's ending character.
//  The rate is set by the single token-state register, which is updated once per
//  character by the step logic between the input register and the result register.
//  Reset (aresetn low, synchronous) empties both registers, clears the token state
//  and loads the register defaults (signed, separator 32, terminator 13).
//  When m_ready is low with a result waiting, any character in the input register
//  is held there and s_ready stays low until the waiting result is taken.
module ascii_number_token_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_value_out,
    output logic                          m_ok,
    input  logic                          cfg_wr_en,
    input  logic [anp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);
    import anp_pkg::*;

    cfg_t        cfg;
    tok_state_t  tok_reg;
    tok_state_t  tok_next;
    tok_result_t res;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_ok_reg;
    logic        advance;

    anp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    anp_step u_step (
        .cfg     (cfg),
        .cur     (tok_reg),
        .char_in (in_char_reg),
        .nxt     (tok_next),
        .res     (res)
    );

    // The held character is processed once there is room for a possible result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tok_reg       <= TOK_CLEAR;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                tok_reg <= tok_next;
            end
            if (advance && res.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
        if (advance && res.emit) begin
            out_value_reg <= res.value_out;
            out_ok_reg    <= res.ok;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_value_out = out_value_reg;
    assign m_ok        = out_ok_reg;

    // A rejected token always reports a zero value.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_value_out == 16'd0))
        else $error("rejected token with nonzero value");

    // The hex digit counter never passes the four-digit limit.
    a_hex_count: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.hex_digit_count <= HEX_MAX_DIGITS)
        else $error("hex digit count out of range");

    // A minus sign and a hex prefix never coexist in one token.
    a_neg_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tok_reg.is_negative && tok_reg.is_hex))
        else $error("negative hex token");

    // Emitting a result restarts the token.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res.emit) |=> (tok_reg == TOK_CLEAR))
        else $error("token state not cleared after result");

    // A failed token keeps its accumulator until the token ends.
    a_fail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (tok_reg.failed && !res.emit) |=> $stable(tok_reg.accum))
        else $error("accumulator changed after failure");

endmodule

// ===== hw/rtl/anp_cfg.sv =====
// Configuration registers of the ASCII number token parser.
module anp_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [anp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_wdata,
    output anp_pkg::cfg_t                  cfg
);
    import anp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIGNED_MODE: cfg_next.signed_mode     = cfg_wdata[0];
                REG_SEPARATOR:   cfg_next.separator_char  = cfg_wdata;
                REG_TERMINATOR:  cfg_next.terminator_char = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.signed_mode     <= 1'b1;
            cfg_reg.separator_char  <= SEPARATOR_RESET;
            cfg_reg.terminator_char <= TERMINATOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/anp_step.sv =====
// Per-character next-state and result logic of the ASCII number token parser.
module anp_step (
    input  anp_pkg::cfg_t       cfg,
    input  anp_pkg::tok_state_t cur,
    input  logic [7:0]          char_in,
    output anp_pkg::tok_state_t nxt,
    output anp_pkg::tok_result_t res
);
    import anp_pkg::*;

    logic        is_end;
    logic        good;
    logic        is_dec;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] mag;
    logic [19:0] mag10;
    logic [19:0] limit;
    logic [15:0] mag10_lo;
    logic        at_start_now;

    assign is_end = (char_in == cfg.separator_char) || (char_in == cfg.terminator_char)
                    || (char_in == CHAR_NUL);
    assign good   = !cur.failed && !cur.x_pending;

    assign is_dec = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (is_dec) begin
            hex_val = 4'(char_in - CHAR_ZERO);
        end else if ((char_in >= CHAR_LA) && (char_in <= CHAR_LF)) begin
            hex_val = 4'(char_in - CHAR_LA + 8'd10);
        end else if ((char_in >= CHAR_UA) && (char_in <= CHAR_UF)) begin
            hex_val = 4'(char_in - CHAR_UA + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Magnitude of a negative accumulator; the most negative value maps onto itself.
    assign mag      = cur.is_negative ? 16'(16'd0 - cur.accum) : cur.accum;
    assign mag10    = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {16'd0, hex_val};
    assign mag10_lo = mag10[15:0];
    assign limit    = cur.is_negative ? LIMIT_SIGNED_NEG
                    : (cfg.signed_mode ? LIMIT_SIGNED_POS : LIMIT_UNSIGNED);

    always_comb begin
        nxt          = cur;
        res.emit     = 1'b0;
        res.ok       = good;
        res.value_out = good ? cur.accum : 16'd0;
        at_start_now = cur.at_start;
        if (is_end) begin
            res.emit = 1'b1;
            nxt      = TOK_CLEAR;
        end else if (!cur.failed) begin
            nxt.at_start = 1'b0;
            if (at_start_now && cfg.signed_mode
                && ((char_in == CHAR_PLUS) || (char_in == CHAR_MINUS))) begin
                nxt.is_negative = (char_in == CHAR_MINUS);
            end else if (!cur.x_pending && (cur.accum == 16'd0) && (char_in == CHAR_X)) begin
                if (cur.is_negative) begin
                    nxt.failed = 1'b1;
                end else begin
                    nxt.is_hex    = 1'b1;
                    nxt.x_pending = 1'b1;
                end
            end else begin
                nxt.x_pending = 1'b0;
                if (cur.is_hex) begin
                    if (!hex_ok || (cur.hex_digit_count >= HEX_MAX_DIGITS)) begin
                        nxt.failed = 1'b1;
                    end else begin
                        nxt.hex_digit_count = cur.hex_digit_count + 3'd1;
                        nxt.accum           = {cur.accum[11:0], hex_val};
                    end
                end else if (!is_dec) begin
                    nxt.failed = 1'b1;
                end else if (mag10 > limit) begin
                    nxt.failed = 1'b1;
                end else begin
                    nxt.accum = cur.is_negative ? 16'(16'd0 - mag10_lo) : mag10_lo;
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the ASCII number token parser.
module testbench;
    import anp_pkg::*;

    // Run control. The limit is far above the slowest legal run, even with
    // every gap and hold-off.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PERCENT = 26;
    localparam int unsigned HOLD_CYCLES  = 300;
    // A result leaves through the input and result registers; characters that
    // end nothing may still sit in the pipeline when the last result is out.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_CAP    = 40;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One row of stimulus. When known is set, the result that this character
    // causes is typed in by hand instead of taken from the predictor.
    typedef struct packed {
        logic [7:0]  ch;
        logic        known;
        logic [15:0] value;
        logic        ok;
    } step_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_char_in = 8'd0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [15:0]          m_value_out;
    logic                 m_ok;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = 8'd0;

    // Shared between the stimulus thread and the receiver. Only the stimulus
    // thread writes quiet and hold_req; the receiver answers a toggle of
    // hold_req by holding m_ready low while a counter loaded with HOLD_CYCLES runs down.
    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // Predictor state: its own copy of the registers and of the token.
    cfg_t        cfg_q;
    tok_state_t  tok;
    // Results still to come, oldest first, and one note per character offered.
    tok_result_t tokens_due[$];
    step_row_t   literal_due[$];
    tok_result_t step_out;
    tok_result_t oldest;
    step_row_t   note;

    // The configuration the stimulus thread has asked for; the predictor
    // takes its own copy from the write port.
    cfg_t        phase_cfg;
    int unsigned chars_sent  = 0;
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;

    // Directed stimulus, run straight after reset with the default registers.
    step_row_t directed_rows [27] = '{
        // An empty token right after reset is a valid zero.
        '{SEPARATOR_RESET,  1'b1, 16'h0000, 1'b1},
        // Most negative signed value.
        '{CHAR_MINUS, 1'b0, 16'h0, 1'b0}, '{"3", 1'b0, 16'h0, 1'b0},
        '{"2", 1'b0, 16'h0, 1'b0}, '{"7", 1'b0, 16'h0, 1'b0},
        '{"6", 1'b0, 16'h0, 1'b0}, '{"8", 1'b0, 16'h0, 1'b0},
        '{SEPARATOR_RESET,  1'b1, 16'h8000, 1'b1},
        // One above the largest positive signed value overflows.
        '{"3", 1'b0, 16'h0, 1'b0}, '{"2", 1'b0, 16'h0, 1'b0},
        '{"7", 1'b0, 16'h0, 1'b0}, '{"6", 1'b0, 16'h0, 1'b0},
        '{"8", 1'b0, 16'h0, 1'b0},
        '{TERMINATOR_RESET, 1'b1, 16'h0000, 1'b0},
        // Four hex digits of mixed case, ended by NUL.
        '{CHAR_X, 1'b0, 16'h0, 1'b0}, '{"f", 1'b0, 16'h0, 1'b0},
        '{"F", 1'b0, 16'h0, 1'b0}, '{"f", 1'b0, 16'h0, 1'b0},
        '{"f", 1'b0, 16'h0, 1'b0},
        '{CHAR_NUL,         1'b1, 16'hFFFF, 1'b1},
        // A hex prefix after a minus sign is an error.
        '{CHAR_MINUS, 1'b0, 16'h0, 1'b0}, '{CHAR_X, 1'b0, 16'h0, 1'b0},
        '{SEPARATOR_RESET,  1'b1, 16'h0000, 1'b0},
        // A prefix with no digit behind it is an error.
        '{CHAR_X, 1'b0, 16'h0, 1'b0},
        '{SEPARATOR_RESET,  1'b1, 16'h0000, 1'b0},
        // A lone sign reads as zero.
        '{CHAR_PLUS, 1'b0, 16'h0, 1'b0},
        '{TERMINATOR_RESET, 1'b1, 16'h0000, 1'b1}
    };

    ascii_number_token_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_ok        (m_ok),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic flag_mismatch(string msg);
        if (err_count < PRINT_CAP) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        err_count++;
    endtask

    // Advances the token by one character and returns the result it causes,
    // if any. The ending test comes first, so an ending byte that is also a
    // sign or a digit always ends the token.
    function automatic tok_result_t parse_token_char(logic [7:0] c);
        tok_result_t r;
        logic        hex_ok;
        logic [3:0]  digit;
        logic [19:0] mag;
        logic [19:0] limit;
        r = '0;
        if (c == cfg_q.separator_char || c == cfg_q.terminator_char || c == CHAR_NUL) begin
            r.emit      = 1'b1;
            r.ok        = !tok.failed && !tok.x_pending;
            r.value_out = r.ok ? tok.accum : 16'd0;
            tok         = TOK_CLEAR;
            return r;
        end
        // After an error the rest of the token is dropped.
        if (tok.failed) return r;
        if (tok.at_start) begin
            tok.at_start = 1'b0;
            if (cfg_q.signed_mode && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                tok.is_negative = (c == CHAR_MINUS);
                return r;
            end
        end
        // A prefix is taken whenever the value is still zero and no prefix is
        // pending, so leading zeros are accepted, but a doubled prefix is not.
        if (!tok.x_pending && tok.accum == 16'd0 && c == CHAR_X) begin
            if (tok.is_negative) begin
                tok.failed = 1'b1;
            end else begin
                tok.is_hex    = 1'b1;
                tok.x_pending = 1'b1;
            end
            return r;
        end
        tok.x_pending = 1'b0;
        if (tok.is_hex) begin
            hex_ok = 1'b1;
            digit  = 4'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                digit = c[3:0];
            end else if (c >= CHAR_LA && c <= CHAR_LF) begin
                digit = 4'(c - CHAR_LA + 8'd10);
            end else if (c >= CHAR_UA && c <= CHAR_UF) begin
                digit = 4'(c - CHAR_UA + 8'd10);
            end else begin
                hex_ok = 1'b0;
            end
            if (!hex_ok || tok.hex_digit_count >= HEX_MAX_DIGITS) begin
                tok.failed = 1'b1;
                return r;
            end
            tok.hex_digit_count = tok.hex_digit_count + 3'd1;
            tok.accum           = {tok.accum[11:0], digit};
            return r;
        end
        if (c < CHAR_ZERO || c > CHAR_NINE) begin
            tok.failed = 1'b1;
            return r;
        end
        // Decimal digits work on the magnitude so that the negative limit is
        // one larger than the positive one.
        if (tok.is_negative) begin
            if (tok.accum == 16'h8000) mag = 20'h08000;
            else mag = {4'd0, 16'(~tok.accum + 16'd1)};
            limit = LIMIT_SIGNED_NEG;
        end else begin
            mag   = {4'd0, tok.accum};
            limit = cfg_q.signed_mode ? LIMIT_SIGNED_POS : LIMIT_UNSIGNED;
        end
        mag = mag * 20'd10 + {16'd0, c[3:0]};
        if (mag > limit) begin
            tok.failed = 1'b1;
            return r;
        end
        tok.accum = tok.is_negative ? 16'(~mag[15:0] + 16'd1) : mag[15:0];
        return r;
    endfunction

    // Watches all three ports at each rising edge. Results are checked before
    // the character of the same edge is predicted; the two can never belong
    // to the same token because the answer passes the input and result registers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_q = '{signed_mode: 1'b1, separator_char: SEPARATOR_RESET,
                      terminator_char: TERMINATOR_RESET};
            tok   = TOK_CLEAR;
        end else begin
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    flag_mismatch($sformatf("result %h ok %b with none due", m_value_out, m_ok));
                end else begin
                    oldest = tokens_due.pop_front();
                    if (m_value_out !== oldest.value_out) begin
                        flag_mismatch($sformatf("value_out got %h want %h",
                                                m_value_out, oldest.value_out));
                    end
                    if (m_ok !== oldest.ok) begin
                        flag_mismatch($sformatf("ok got %b want %b", m_ok, oldest.ok));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SIGNED_MODE: cfg_q.signed_mode     = cfg_wdata[0];
                    REG_SEPARATOR:   cfg_q.separator_char  = cfg_wdata;
                    REG_TERMINATOR:  cfg_q.terminator_char = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                note     = (literal_due.size() != 0) ? literal_due.pop_front() : '0;
                step_out = parse_token_char(s_char_in);
                if (step_out.emit) begin
                    // A hand-typed row overrides the predictor for that result.
                    if (note.known) begin
                        step_out.value_out = note.value;
                        step_out.ok        = note.ok;
                    end
                    tokens_due.push_back(step_out);
                end
            end
        end
    end

    // Result side: random idling, no idling while quiet is set, and a long
    // hold-off on request so that the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offers one character and returns at the edge of its transfer. Valid is
    // left high so that the next character can follow without a bubble; it
    // is only lowered when a gap is chosen or a phase ends.
    task automatic send_char(logic [7:0] c, logic known, logic [15:0] value, logic ok);
        if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        literal_due.push_back('{c, known, value, ok});
        s_valid   <= 1'b1;
        s_char_in <= c;
        chars_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Builds one token, mostly well formed with random content: decimal
    // numbers around the limits, hex with and without digits, a share with
    // one byte spoiled, and some plain noise. When close is clear the token
    // is left open, so that the next register writes land inside a token.
    task automatic send_random_token(bit close);
        logic [7:0]  text[$];
        string       digits;
        int unsigned kind;
        int unsigned n;
        int unsigned v;
        int unsigned d;
        kind = $urandom_range(99);
        if (kind < 85) begin
            if ($urandom_range(3) == 0) begin
                text.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
            end
            if (kind < 45) begin
                case ($urandom_range(4))
                    0:       v = $urandom_range(99);
                    1:       v = $urandom_range(65535);
                    2:       v = 32766 + $urandom_range(3);
                    3:       v = 65534 + $urandom_range(2);
                    default: v = $urandom_range(999999);
                endcase
                if ($urandom_range(7) == 0) text.push_back(CHAR_ZERO);
                digits = $sformatf("%0d", v);
                for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
            end else begin
                if ($urandom_range(5) == 0) text.push_back(CHAR_ZERO);
                text.push_back(CHAR_X);
                if ($urandom_range(7) == 0) text.push_back(CHAR_X);
                // Mostly up to four digits, sometimes the fifth one that fails.
                n = ($urandom_range(9) == 0) ? 5 : $urandom_range(4);
                repeat (n) begin
                    d = $urandom_range(15);
                    if (d < 10) text.push_back(8'(CHAR_ZERO + d));
                    else text.push_back(8'(($urandom_range(1) ? CHAR_UA : CHAR_LA) + d - 10));
                end
            end
            if ($urandom_range(6) == 0) begin
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            end
        end else begin
            repeat ($urandom_range(5, 1)) text.push_back(8'($urandom_range(255)));
        end
        if (close) begin
            case ($urandom_range(3))
                0, 1:    text.push_back(phase_cfg.separator_char);
                2:       text.push_back(phase_cfg.terminator_char);
                default: text.push_back(CHAR_NUL);
            endcase
        end
        foreach (text[i]) send_char(text[i], 1'b0, 16'd0, 1'b0);
    endtask

    // Brings the block to rest: input lowered, every due result taken, then
    // a drain wait for characters that cause no result.
    task automatic finish_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // One phase of random tokens under one register setting. The signed
    // mode write carries random upper bits, which the block must ignore.
    task automatic run_phase(logic mode, logic [7:0] sep, logic [7:0] term,
                             int unsigned budget, bit no_idle, bit squeeze);
        int unsigned stop_at;
        write_reg(REG_SIGNED_MODE, {7'($urandom), mode});
        write_reg(REG_SEPARATOR, sep);
        write_reg(REG_TERMINATOR, term);
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_wr_en <= 1'b0;
        phase_cfg = '{signed_mode: mode, separator_char: sep, terminator_char: term};
        quiet <= no_idle;
        if (squeeze) hold_req <= ~hold_req;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) send_random_token(1'b1);
        if ($urandom_range(1)) send_random_token(1'b0);
        finish_phase();
        quiet <= 1'b0;
    endtask

    initial begin
        phase_cfg = '{signed_mode: 1'b1, separator_char: SEPARATOR_RESET,
                      terminator_char: TERMINATOR_RESET};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].ch, directed_rows[i].known,
                      directed_rows[i].value, directed_rows[i].ok);
        end
        finish_phase();

        // Defaults written back explicitly, then the extremes of both ending
        // bytes in unsigned mode, one phase at full rate on both sides, one
        // with the long receiver hold-off, one whose ending bytes are a sign
        // and a digit, and a few fully random settings.
        run_phase(1'b1, SEPARATOR_RESET, TERMINATOR_RESET, 300, 1'b0, 1'b0);
        run_phase(1'b0, 8'hFF, 8'h00, 300, 1'b0, 1'b0);
        run_phase(1'b0, 8'h00, 8'hFF, 300, 1'b1, 1'b0);
        run_phase(1'b1, ",", ";", 300, 1'b0, 1'b1);
        run_phase(1'b1, CHAR_MINUS, "5", 200, 1'b0, 1'b0);
        repeat (3) begin
            run_phase(1'($urandom), 8'($urandom), 8'($urandom), 200, 1'b0, 1'b0);
        end

        if (tokens_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", tokens_due.size()));
        end
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/anp_pkg.sv
hw/rtl/anp_cfg.sv
hw/rtl/anp_step.sv
hw/rtl/ascii_number_token_parser.sv
dv/testbench.sv
